/* rtl/ihd_pkg.sv */
package ihd_pkg;

  localparam int HEAP_DEPTH   = 1024;
  localparam int KEY_BITS     = 32;
  localparam int PAYLOAD_BITS = 32;
  localparam int ADDR_BITS    = $clog2(HEAP_DEPTH);
  localparam int IDX_BITS     = 10;
  localparam int CNT_BITS     = 11;
  localparam int WALK_BITS    = CNT_BITS + 1;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_POP     = 2'd1,
    MODE_REPLACE = 2'd2,
    MODE_NOP     = 2'd3
  } mode_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP_RD_LAST,
    S_POP_RD_ROOT,
    S_POP_RD_C,
    S_POP_RD_R,
    S_POP_CMP,
    S_POP_RD_HI,
    S_POP_TRADE,
    S_RP_CHK0,
    S_RP_LOOP,
    S_RP_RD_C,
    S_RP_CMP,
    S_RP_RD_LO,
    S_RP_TRADE,
    S_RP_END,
    S_RP_END_RD,
    S_RP_END_CMP,
    S_RP_END_ONE,
    S_RP_END_LO,
    S_RP_END_TRADE,
    S_FINAL,
    S_RD_OUT,
    S_GET_OUT,
    S_OUT
  } state_t;

endpackage

/* rtl/ihd_store.sv */
module ihd_store #(
  parameter int DEPTH  = 1024,
  parameter int KBITS  = 32,
  parameter int PBITS  = 32,
  parameter int ABITS  = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ABITS-1:0] waddr,
  input  logic [KBITS-1:0] wkey,
  input  logic [PBITS-1:0] wpay,
  input  logic [ABITS-1:0] raddr,
  output logic [KBITS-1:0] rkey,
  output logic [PBITS-1:0] rpay
);
  logic [KBITS-1:0] key_mem [DEPTH];
  logic [PBITS-1:0] pay_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      pay_mem[waddr] <= wpay;
    end
    rkey <= key_mem[raddr];
    rpay <= pay_mem[raddr];
  end
endmodule

/* rtl/interval_heap_deque_top.sv */
// channel | handshake            | fields
// in      | in_valid, in_ready   | in_mode in_slot_index in_entry_key in_entry_payload
// out     | out_valid, out_ready | out_key out_payload out_entry_count out_error_flag
// one item at a time; in_ready is high only in idle. a load, a no-op or an empty-heap
// error goes straight to the output register; a replace on one entry only rewrites the
// root, a pop or replace walks down the heap (9 levels at most), and a replace reaching
// the heap bottom also handles the last node. reset clears the count and control; the
// slot memory is left unwritten. a result waits in the output register until taken;
// idle follows in the next cycle.
module interval_heap_deque_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_mode,
  input  logic [ihd_pkg::IDX_BITS-1:0]         in_slot_index,
  input  logic signed [ihd_pkg::KEY_BITS-1:0]  in_entry_key,
  input  logic [ihd_pkg::PAYLOAD_BITS-1:0]     in_entry_payload,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [ihd_pkg::KEY_BITS-1:0]  out_key,
  output logic [ihd_pkg::PAYLOAD_BITS-1:0]     out_payload,
  output logic [ihd_pkg::CNT_BITS-1:0]         out_entry_count,
  output logic                                 out_error_flag
);
  import ihd_pkg::*;

  state_t state_r, state_nxt;
  logic [WALK_BITS-1:0] cnt_r, cnt_nxt;
  logic [WALK_BITS-1:0] n_r, n_nxt, pos_r, pos_nxt, c_r, c_nxt, lim_r, lim_nxt;
  logic [WALK_BITS-1:0] top_r, top_nxt;
  mode_t mode_r, mode_nxt;
  logic [IDX_BITS-1:0] idx_r, idx_nxt;
  logic signed [KEY_BITS-1:0] nk_r, nk_nxt, ck_r, ck_nxt;
  logic [PAYLOAD_BITS-1:0] np_r, np_nxt, cp_r, cp_nxt;
  logic signed [KEY_BITS-1:0] ok_r, ok_nxt;
  logic [PAYLOAD_BITS-1:0] op_r, op_nxt;
  logic err_r, err_nxt;

  logic we;
  logic [ADDR_BITS-1:0] waddr, raddr;
  logic [WALK_BITS-1:0] waddr_w, raddr_w;
  logic signed [KEY_BITS-1:0] wkey, rkey;
  logic [PAYLOAD_BITS-1:0] wpay, rpay;

  assign waddr = waddr_w[ADDR_BITS-1:0];
  assign raddr = raddr_w[ADDR_BITS-1:0];

  ihd_store #(.DEPTH(HEAP_DEPTH), .KBITS(KEY_BITS), .PBITS(PAYLOAD_BITS), .ABITS(ADDR_BITS))
    u_store (.clk, .we, .waddr, .wkey, .wpay, .raddr, .rkey, .rpay);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    n_r <= n_nxt; pos_r <= pos_nxt; c_r <= c_nxt; lim_r <= lim_nxt;
    top_r <= top_nxt; mode_r <= mode_nxt; idx_r <= idx_nxt;
    nk_r <= nk_nxt; np_r <= np_nxt; ck_r <= ck_nxt; cp_r <= cp_nxt;
    ok_r <= ok_nxt; op_r <= op_nxt; err_r <= err_nxt;
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = (state_r == S_OUT);
  assign out_key         = ok_r;
  assign out_payload     = op_r;
  assign out_entry_count = cnt_r[CNT_BITS-1:0];
  assign out_error_flag  = err_r;

  // one shared signed compare
  logic lt_a_b;
  logic signed [KEY_BITS-1:0] cmp_a, cmp_b;
  assign lt_a_b = cmp_a < cmp_b;

  always_comb begin
    cmp_a = nk_r;
    cmp_b = rkey;
    unique case (state_r)
      S_POP_CMP: begin
        cmp_a = rkey; cmp_b = ck_r;
      end
      S_POP_RD_HI, S_RP_END_LO: begin
        cmp_a = nk_r; cmp_b = ck_r;
      end
      S_POP_TRADE: begin
        cmp_a = rkey; cmp_b = nk_r;
      end
      S_RP_CMP, S_RP_END_CMP: begin
        cmp_a = ck_r; cmp_b = rkey;
      end
      S_RP_RD_LO: begin
        cmp_a = ck_r; cmp_b = nk_r;
      end
      default: begin
        cmp_a = nk_r; cmp_b = rkey;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (mode_r)
          MODE_LOAD, MODE_NOP: state_nxt = S_OUT;
          MODE_POP: begin
            if (cnt_r == '0) state_nxt = S_OUT;
            else state_nxt = S_POP_RD_LAST;
          end
          MODE_REPLACE: begin
            if (cnt_r == '0) state_nxt = S_OUT;
            else if (cnt_r == WALK_BITS'(1)) state_nxt = S_FINAL;
            else state_nxt = S_RP_CHK0;
          end
        endcase
      end
      S_POP_RD_LAST: state_nxt = S_POP_RD_ROOT;
      S_POP_RD_ROOT: state_nxt = S_POP_RD_C;
      S_POP_RD_C: begin
        if (c_r < n_r) state_nxt = S_POP_RD_R;
        else state_nxt = S_FINAL;
      end
      S_POP_RD_R: state_nxt = S_POP_CMP;
      S_POP_CMP: state_nxt = S_POP_RD_HI;
      S_POP_RD_HI: begin
        if (lt_a_b) state_nxt = S_FINAL;
        else state_nxt = S_POP_TRADE;
      end
      S_POP_TRADE: state_nxt = S_POP_RD_C;
      S_RP_CHK0: state_nxt = S_RP_LOOP;
      S_RP_LOOP: begin
        if (c_r < lim_r) state_nxt = S_RP_RD_C;
        else state_nxt = S_RP_END;
      end
      S_RP_RD_C: state_nxt = S_RP_CMP;
      S_RP_CMP: state_nxt = S_RP_RD_LO;
      S_RP_RD_LO: begin
        if (lt_a_b) state_nxt = S_FINAL;
        else state_nxt = S_RP_TRADE;
      end
      S_RP_TRADE: state_nxt = S_RP_LOOP;
      S_RP_END: begin
        if (c_r > cnt_r) state_nxt = S_FINAL;
        else if ((cnt_r - c_r) == WALK_BITS'(2)) state_nxt = S_RP_END_RD;
        else state_nxt = S_RP_END_ONE;
      end
      S_RP_END_RD: state_nxt = S_RP_END_CMP;
      S_RP_END_CMP: state_nxt = S_RP_END_LO;
      S_RP_END_ONE: state_nxt = S_RP_END_LO;
      S_RP_END_LO: begin
        if (lt_a_b && c_r[0]) state_nxt = S_RP_END_TRADE;
        else state_nxt = S_FINAL;
      end
      S_RP_END_TRADE: state_nxt = S_FINAL;
      S_FINAL: state_nxt = S_RD_OUT;
      S_RD_OUT: state_nxt = S_GET_OUT;
      S_GET_OUT: state_nxt = S_OUT;
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and slot memory control
  always_comb begin
    cnt_nxt = cnt_r; n_nxt = n_r; pos_nxt = pos_r; c_nxt = c_r; lim_nxt = lim_r;
    top_nxt = top_r; mode_nxt = mode_r; idx_nxt = idx_r;
    nk_nxt = nk_r; np_nxt = np_r; ck_nxt = ck_r; cp_nxt = cp_r;
    ok_nxt = ok_r; op_nxt = op_r; err_nxt = err_r;
    we = 1'b0; waddr_w = '0; raddr_w = '0; wkey = nk_r; wpay = np_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt = mode_t'(in_mode); idx_nxt = in_slot_index;
          nk_nxt = in_entry_key; np_nxt = in_entry_payload;
          ok_nxt = '0; op_nxt = '0; err_nxt = 1'b0;
        end
      end
      S_DISPATCH: begin
        unique case (mode_r)
          MODE_LOAD: begin
            if (WALK_BITS'(idx_r) < WALK_BITS'(HEAP_DEPTH)) begin
              we = 1'b1; waddr_w = WALK_BITS'(idx_r);
              cnt_nxt = WALK_BITS'(idx_r) + WALK_BITS'(1);
            end
          end
          MODE_POP: begin
            if (cnt_r == '0) begin
              err_nxt = 1'b1;
            end else begin
              n_nxt = cnt_r - WALK_BITS'(1);
              top_nxt = cnt_r - WALK_BITS'(1);
              cnt_nxt = cnt_r - WALK_BITS'(1);
              pos_nxt = '0; c_nxt = WALK_BITS'(2);
              raddr_w = cnt_r - WALK_BITS'(1);
            end
          end
          MODE_REPLACE: begin
            if (cnt_r == '0) begin
              err_nxt = 1'b1;
            end else if (cnt_r == WALK_BITS'(1)) begin
              top_nxt = '0; pos_nxt = '0;
            end else begin
              top_nxt = WALK_BITS'(1); pos_nxt = WALK_BITS'(1); c_nxt = WALK_BITS'(3);
              lim_nxt = (cnt_r - WALK_BITS'(2)) & ~WALK_BITS'(3);
              raddr_w = '0;
            end
          end
          MODE_NOP: ;
        endcase
      end
      // ---- pop min
      S_POP_RD_LAST: begin
        nk_nxt = rkey; np_nxt = rpay;
        raddr_w = '0;
      end
      S_POP_RD_ROOT: begin
        we = 1'b1; waddr_w = n_r; wkey = rkey; wpay = rpay;
      end
      S_POP_RD_C: begin
        raddr_w = c_r;
      end
      S_POP_RD_R: begin
        ck_nxt = rkey; cp_nxt = rpay;
        raddr_w = c_r + WALK_BITS'(2);
      end
      S_POP_CMP: begin
        if ((c_r + WALK_BITS'(2)) < n_r && lt_a_b) begin
          c_nxt = c_r + WALK_BITS'(2); ck_nxt = rkey; cp_nxt = rpay;
        end
      end
      S_POP_RD_HI: begin
        if (!lt_a_b) begin
          we = 1'b1; waddr_w = pos_r; wkey = ck_r; wpay = cp_r;
        end
        raddr_w = c_r + WALK_BITS'(1);
      end
      S_POP_TRADE: begin
        if ((c_r + WALK_BITS'(1)) < n_r && lt_a_b) begin
          we = 1'b1; waddr_w = c_r + WALK_BITS'(1);
          nk_nxt = rkey; np_nxt = rpay;
        end
        pos_nxt = c_r; c_nxt = (c_r << 1) + WALK_BITS'(2);
      end
      // ---- replace max
      S_RP_CHK0: begin
        if (lt_a_b) begin
          we = 1'b1; waddr_w = '0;
          nk_nxt = rkey; np_nxt = rpay;
        end
      end
      S_RP_LOOP: begin
        raddr_w = c_r;
      end
      S_RP_RD_C: begin
        ck_nxt = rkey; cp_nxt = rpay;
        raddr_w = c_r + WALK_BITS'(2);
      end
      S_RP_CMP: begin
        if (lt_a_b) begin
          c_nxt = c_r + WALK_BITS'(2); ck_nxt = rkey; cp_nxt = rpay;
        end
      end
      S_RP_RD_LO: begin
        if (!lt_a_b) begin
          we = 1'b1; waddr_w = pos_r; wkey = ck_r; wpay = cp_r;
        end
        raddr_w = c_r - WALK_BITS'(1);
      end
      S_RP_TRADE: begin
        if (lt_a_b) begin
          we = 1'b1; waddr_w = c_r - WALK_BITS'(1);
          nk_nxt = rkey; np_nxt = rpay;
        end
        pos_nxt = c_r; c_nxt = (c_r << 1) + WALK_BITS'(1);
      end
      S_RP_END: begin
        // a single-entry last node is read at its low slot
        if (cnt_r == c_r) begin
          c_nxt = c_r - WALK_BITS'(1); raddr_w = c_r - WALK_BITS'(1);
        end else begin
          raddr_w = c_r;
        end
      end
      S_RP_END_RD: begin
        ck_nxt = rkey; cp_nxt = rpay;
        raddr_w = c_r + WALK_BITS'(1);
      end
      S_RP_END_CMP: begin
        if (lt_a_b) begin
          c_nxt = c_r + WALK_BITS'(1); ck_nxt = rkey; cp_nxt = rpay;
        end
      end
      S_RP_END_ONE: begin
        ck_nxt = rkey; cp_nxt = rpay;
      end
      S_RP_END_LO: begin
        if (lt_a_b) begin
          we = 1'b1; waddr_w = pos_r; wkey = ck_r; wpay = cp_r;
          pos_nxt = c_r;
        end
        raddr_w = c_r - WALK_BITS'(1);
      end
      S_RP_END_TRADE: begin
        if (lt_a_b) begin
          we = 1'b1; waddr_w = c_r - WALK_BITS'(1);
          nk_nxt = rkey; np_nxt = rpay;
        end
      end
      // ---- result
      S_FINAL: begin
        we = 1'b1; waddr_w = pos_r;
      end
      S_RD_OUT: begin
        raddr_w = top_r;
      end
      S_GET_OUT: begin
        ok_nxt = rkey; op_nxt = rpay;
      end
      S_OUT: ;
      default: ;
    endcase
  end
endmodule
